>>> rtl/assert_macros.svh
// Assertion macros for the RTL; only pid_tuning_from_step_model_unit.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property on every clock edge while reset is released.
`define ASSERT_CLK(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Checks a property on the edge that follows an edge with reset asserted.
`define ASSERT_RESET(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) !rn |=> prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, ck, rn, prop, msg)
`define ASSERT_RESET(lbl, ck, rn, prop, msg)

`endif

`endif

>>> rtl/pidcc_pkg.sv
package pidcc_pkg;

  localparam int FRAC_BITS = 16;

  localparam int DATA_W    = 32;
  localparam int DIV_STEPS = 32;
  localparam int DIV_W     = 80;
  localparam int T2_W      = 36;
  localparam int KPN_W     = 48;
  localparam int K1K_W     = 42;
  localparam int NUM2_W    = 49;
  localparam int DEN2_W    = 50;
  localparam int DKP_W     = 78;
  localparam int PT_W      = 85;
  localparam int KPD_W     = KPN_W + 2 * FRAC_BITS;
  localparam int KID_W     = DATA_W + FRAC_BITS;
  localparam int SQ_REM_W  = 35;

  typedef enum logic [1:0] {
    MODE_P   = 2'd0,
    MODE_PI  = 2'd1,
    MODE_PD  = 2'd2,
    MODE_PID = 2'd3
  } mode_t;

  function automatic logic [10:0] kp_coef_a(mode_t m);
    logic [10:0] c;
    unique case (m)
      MODE_P:   c = 11'd1000;
      MODE_PI:  c = 11'd900;
      MODE_PD:  c = 11'd1240;
      MODE_PID: c = 11'd1350;
      default:  c = 11'd1000;
    endcase
    return c;
  endfunction

  function automatic logic [10:0] kp_coef_b(mode_t m);
    logic [10:0] c;
    unique case (m)
      MODE_P:   c = 11'd333;
      MODE_PI:  c = 11'd83;
      MODE_PD:  c = 11'd120;
      MODE_PID: c = 11'd270;
      default:  c = 11'd333;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/pidcc_div.sv
module pidcc_div import pidcc_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [DIV_W-1:0]  rem_in,
  input  logic [DATA_W-1:0] low_in,
  input  logic [DIV_W-1:0]  den_in,
  input  logic              sat_in,
  output logic [DATA_W-1:0] quo,
  output logic              sat
);

  logic [DIV_W-1:0]  rem_r   [DIV_STEPS];
  logic [DIV_W-1:0]  rem_nxt [DIV_STEPS];
  logic [DIV_W-1:0]  rem_src [DIV_STEPS];
  logic [DIV_W-1:0]  rem_sh  [DIV_STEPS];
  logic [DIV_W-1:0]  den_r   [DIV_STEPS];
  logic [DIV_W-1:0]  den_src [DIV_STEPS];
  logic [DATA_W-1:0] low_r   [DIV_STEPS];
  logic [DATA_W-1:0] low_nxt [DIV_STEPS];
  logic [DATA_W-1:0] low_src [DIV_STEPS];
  logic [DATA_W-1:0] quo_r   [DIV_STEPS];
  logic [DATA_W-1:0] quo_nxt [DIV_STEPS];
  logic [DATA_W-1:0] quo_src [DIV_STEPS];
  logic              sat_r   [DIV_STEPS];
  logic              sat_src [DIV_STEPS];

  // Restoring division, one quotient bit per stage.
  always_comb begin
    rem_src[0] = rem_in;
    den_src[0] = den_in;
    low_src[0] = low_in;
    quo_src[0] = '0;
    sat_src[0] = sat_in;
    for (int k = 1; k < DIV_STEPS; k++) begin
      rem_src[k] = rem_r[k-1];
      den_src[k] = den_r[k-1];
      low_src[k] = low_r[k-1];
      quo_src[k] = quo_r[k-1];
      sat_src[k] = sat_r[k-1];
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      rem_sh[k]  = {rem_src[k][DIV_W-2:0], low_src[k][DATA_W-1]};
      low_nxt[k] = {low_src[k][DATA_W-2:0], 1'b0};
      if (rem_sh[k] >= den_src[k]) begin
        rem_nxt[k] = rem_sh[k] - den_src[k];
        quo_nxt[k] = {quo_src[k][DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt[k] = rem_sh[k];
        quo_nxt[k] = {quo_src[k][DATA_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      den_r <= den_src;
      low_r <= low_nxt;
      quo_r <= quo_nxt;
      sat_r <= sat_src;
    end
  end

  assign quo = quo_r[DIV_STEPS-1];
  assign sat = sat_r[DIV_STEPS-1];

endmodule

>>> rtl/pidcc_sqrt.sv
module pidcc_sqrt import pidcc_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [2*DATA_W-1:0] rad_in,
  output logic [DATA_W-1:0]   root
);

  logic [SQ_REM_W-1:0] rem_r   [DATA_W];
  logic [SQ_REM_W-1:0] rem_nxt [DATA_W];
  logic [SQ_REM_W-1:0] rem_src [DATA_W];
  logic [SQ_REM_W-1:0] rem_sh  [DATA_W];
  logic [SQ_REM_W-1:0] trial   [DATA_W];
  logic [2*DATA_W-1:0] rad_r   [DATA_W];
  logic [2*DATA_W-1:0] rad_src [DATA_W];
  logic [DATA_W-1:0]   res_r   [DATA_W];
  logic [DATA_W-1:0]   res_nxt [DATA_W];
  logic [DATA_W-1:0]   res_src [DATA_W];

  // Digit-by-digit square root, one result bit per stage.
  always_comb begin
    rem_src[0] = '0;
    rad_src[0] = rad_in;
    res_src[0] = '0;
    for (int k = 1; k < DATA_W; k++) begin
      rem_src[k] = rem_r[k-1];
      rad_src[k] = rad_r[k-1];
      res_src[k] = res_r[k-1];
    end
    for (int k = 0; k < DATA_W; k++) begin
      rem_sh[k] = {rem_src[k][SQ_REM_W-3:0], rad_src[k][2*DATA_W-1 -: 2]};
      trial[k]  = SQ_REM_W'({res_src[k], 2'b01});
      if (rem_sh[k] >= trial[k]) begin
        rem_nxt[k] = rem_sh[k] - trial[k];
        res_nxt[k] = {res_src[k][DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt[k] = rem_sh[k];
        res_nxt[k] = {res_src[k][DATA_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      res_r <= res_nxt;
      for (int k = 0; k < DATA_W; k++) begin
        rad_r[k] <= {rad_src[k][2*DATA_W-3:0], 2'b00};
      end
    end
  end

  assign root = res_r[DATA_W-1];

endmodule

>>> rtl/pid_tuning_from_step_model_unit.sv
// Pipeline: 72 register stages, all moved together by one common enable.
// Throughput: one request per cycle while the output is not stalled; every stage is
// registered, and two ranks of 32-stage restoring dividers, the second beside a
// 32-stage square root, set the depth.
// A result held on the output stalls the whole pipeline; nothing is lost.
// Reset (rst_n low, synchronous) clears the valid bits; data is not reset.
`include "assert_macros.svh"

module pid_tuning_from_step_model_unit import pidcc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       in_process_gain,
  input  logic [31:0]       in_time_constant,
  input  logic [31:0]       in_dead_time,
  input  logic [3:0]        in_lag_order,
  input  logic [1:0]        in_controller_mode,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_status,
  output logic [31:0]       out_prop_gain,
  output logic [31:0]       out_integral_time,
  output logic [31:0]       out_derivative_time,
  output logic [31:0]       out_integral_gain,
  output logic [31:0]       out_derivative_gain,
  output logic [31:0]       out_tracking_time
);

  localparam int PIPE_LEN = 5 + DIV_STEPS + 2 + DIV_STEPS + 1;

  typedef struct packed {
    logic  inv;
    mode_t mode;
    logic  td_pos;
  } mid_t;

  typedef struct packed {
    logic                inv;
    logic [DATA_W-1:0]   kp;
    logic [DATA_W-1:0]   ti;
    logic [DATA_W-1:0]   td;
    logic [2*DATA_W-1:0] kd_prod;
  } late_t;

  logic                en;
  logic [PIPE_LEN-1:0] vld_r;

  // Stage A
  logic [DATA_W-1:0] a_k_r;
  logic [T2_W-1:0]   a_t2_r, a_l2_r;
  mode_t             a_mode_r;
  logic              a_inv_r;
  logic [4:0]        a_n1;

  // Stage B
  logic [KPN_W-1:0]  b_kpnum_r;
  logic [K1K_W-1:0]  b_k1k_r;
  logic [T2_W-1:0]   b_l2_r;
  logic [NUM2_W-1:0] b_ti_num_r, b_td_num_r;
  logic [DEN2_W-1:0] b_ti_den_r, b_td_den_r;
  logic              b_inv_r, b_tdpos_r;
  mode_t             b_mode_r;
  logic [NUM2_W-1:0] td_hi, td_lo;
  logic              td_gt;

  // Stage C
  logic [K1K_W+17:0] c_dkp_lo_r, c_dkp_hi_r;
  logic [T2_W+24:0]  c_pti_lo_r, c_ptd_lo_r;
  logic [T2_W+23:0]  c_pti_hi_r, c_ptd_hi_r;
  logic [KPN_W-1:0]  c_kpnum_r;
  logic [DEN2_W-1:0] c_ti_den_r, c_td_den_r;
  mid_t              c_mid_r;

  // Stage D
  logic [DKP_W-1:0]  d_dkp_r;
  logic [PT_W-1:0]   d_pti_r, d_ptd_r;
  logic [KPN_W-1:0]  d_kpnum_r;
  logic [DEN2_W-1:0] d_ti_den_r, d_td_den_r;
  mid_t              d_mid_r;
  logic [KPD_W-1:0]  kp_dvd;

  // Stage E, divider inputs
  logic [DIV_W-1:0]  e_kp_rem_r, e_kp_den_r, e_ti_rem_r, e_ti_den_r, e_td_rem_r, e_td_den_r;
  logic [DATA_W-1:0] e_kp_low_r, e_ti_low_r, e_td_low_r;
  logic              e_kp_sat_r, e_ti_sat_r, e_td_sat_r;
  mid_t              e_mid_r;
  logic [DIV_W-1:0]  kp_rem_nxt, ti_rem_nxt, td_rem_nxt;
  logic [DIV_W-1:0]  kp_den_nxt, ti_den_nxt, td_den_nxt;

  mid_t              mid_r [DIV_STEPS];
  logic [DATA_W-1:0] kp_quo, ti_quo, td_quo;
  logic              kp_sat, ti_sat, td_sat;

  // Stage F
  logic [DATA_W-1:0] f_kp_r, f_ti_r, f_td_r;
  logic              f_inv_r;
  mid_t              mid_end;

  // Stage G
  logic [DIV_W-1:0]    g_ki_rem_r, g_ki_den_r;
  logic [DATA_W-1:0]   g_ki_low_r;
  logic                g_ki_sat_r;
  logic [2*DATA_W-1:0] g_rad_r;
  late_t               g_late_r;
  logic [KID_W-1:0]    ki_dvd;
  logic [DATA_W-1:0]   ki_hi;

  late_t               late_r [DIV_STEPS];
  late_t               late_end;
  logic [DATA_W-1:0]   ki_quo, tt_root;
  logic                ki_sat;

  // Output stage
  logic              out_status_r;
  logic [DATA_W-1:0] out_kp_r, out_ti_r, out_td_r, out_ki_r, out_kd_r, out_tt_r;

  logic              chk_inv, chk_zero, chk_no_ti, chk_no_td, chk_ki_zero, chk_tt_ti;

  assign en       = !vld_r[PIPE_LEN-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LEN-2:0], in_valid};
    end
  end

  // Stage A: half-rule reduction, times kept doubled.
  assign a_n1 = {1'b0, in_lag_order} + 5'd1;

  always_ff @(posedge clk) begin
    if (en) begin
      a_k_r    <= in_process_gain;
      a_t2_r   <= T2_W'(in_time_constant) * T2_W'(a_n1);
      a_l2_r   <= T2_W'({in_dead_time, 1'b0})
                + T2_W'(in_time_constant) * T2_W'(in_lag_order - 4'd1);
      a_mode_r <= mode_t'(in_controller_mode);
      a_inv_r  <= (in_process_gain == '0) || (in_time_constant == '0) ||
                  (in_lag_order == '0);
    end
  end

  // Stage B: numerators and denominators of the tuning rules.
  assign td_hi = NUM2_W'(270) * NUM2_W'(a_t2_r);
  assign td_lo = NUM2_W'(36) * NUM2_W'(a_l2_r);
  assign td_gt = td_hi > td_lo;

  always_ff @(posedge clk) begin
    if (en) begin
      b_kpnum_r <= KPN_W'(kp_coef_a(a_mode_r)) * KPN_W'(a_t2_r)
                 + KPN_W'(kp_coef_b(a_mode_r)) * KPN_W'(a_l2_r);
      b_k1k_r   <= K1K_W'(a_k_r) * K1K_W'(1000);
      b_l2_r    <= a_l2_r;
      if (a_mode_r == MODE_PI) begin
        b_ti_num_r <= NUM2_W'(3330) * NUM2_W'(a_t2_r) + NUM2_W'(300) * NUM2_W'(a_l2_r);
        b_ti_den_r <= (DEN2_W'(1000) * DEN2_W'(a_t2_r)
                     + DEN2_W'(2200) * DEN2_W'(a_l2_r)) << 1;
      end else begin
        b_ti_num_r <= NUM2_W'(2500) * NUM2_W'(a_t2_r) + NUM2_W'(460) * NUM2_W'(a_l2_r);
        b_ti_den_r <= (DEN2_W'(1000) * DEN2_W'(a_t2_r)
                     + DEN2_W'(610) * DEN2_W'(a_l2_r)) << 1;
      end
      if (a_mode_r == MODE_PD) begin
        b_td_num_r <= td_gt ? (td_hi - td_lo) : '0;
        b_td_den_r <= (DEN2_W'(1000) * DEN2_W'(a_t2_r)
                     + DEN2_W'(870) * DEN2_W'(a_l2_r)) << 1;
        b_tdpos_r  <= td_gt;
      end else begin
        b_td_num_r <= NUM2_W'(370) * NUM2_W'(a_t2_r);
        b_td_den_r <= (DEN2_W'(1000) * DEN2_W'(a_t2_r)
                     + DEN2_W'(190) * DEN2_W'(a_l2_r)) << 1;
        b_tdpos_r  <= 1'b1;
      end
      b_inv_r  <= a_inv_r || (a_l2_r == '0);
      b_mode_r <= a_mode_r;
    end
  end

  // Stage C: partial products of the wide multiplications.
  always_ff @(posedge clk) begin
    if (en) begin
      c_dkp_lo_r <= (K1K_W+18)'(b_k1k_r) * (K1K_W+18)'(b_l2_r[17:0]);
      c_dkp_hi_r <= (K1K_W+18)'(b_k1k_r) * (K1K_W+18)'(b_l2_r[35:18]);
      c_pti_lo_r <= (T2_W+25)'(b_l2_r) * (T2_W+25)'(b_ti_num_r[24:0]);
      c_pti_hi_r <= (T2_W+24)'(b_l2_r) * (T2_W+24)'(b_ti_num_r[48:25]);
      c_ptd_lo_r <= (T2_W+25)'(b_l2_r) * (T2_W+25)'(b_td_num_r[24:0]);
      c_ptd_hi_r <= (T2_W+24)'(b_l2_r) * (T2_W+24)'(b_td_num_r[48:25]);
      c_kpnum_r  <= b_kpnum_r;
      c_ti_den_r <= b_ti_den_r;
      c_td_den_r <= b_td_den_r;
      c_mid_r    <= '{inv: b_inv_r, mode: b_mode_r, td_pos: b_tdpos_r};
    end
  end

  // Stage D: sum the partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      d_dkp_r    <= DKP_W'(c_dkp_lo_r) + (DKP_W'(c_dkp_hi_r) << 18);
      d_pti_r    <= PT_W'(c_pti_lo_r) + (PT_W'(c_pti_hi_r) << 25);
      d_ptd_r    <= PT_W'(c_ptd_lo_r) + (PT_W'(c_ptd_hi_r) << 25);
      d_kpnum_r  <= c_kpnum_r;
      d_ti_den_r <= c_ti_den_r;
      d_td_den_r <= c_td_den_r;
      d_mid_r    <= c_mid_r;
    end
  end

  // Stage E: split each dividend and flag quotients that overflow 32 bits.
  assign kp_dvd     = {d_kpnum_r, {(2*FRAC_BITS){1'b0}}};
  assign kp_rem_nxt = DIV_W'(kp_dvd[KPD_W-1:DATA_W]);
  assign kp_den_nxt = DIV_W'(d_dkp_r);
  assign ti_rem_nxt = DIV_W'(d_pti_r[PT_W-1:DATA_W]);
  assign ti_den_nxt = DIV_W'(d_ti_den_r);
  assign td_rem_nxt = DIV_W'(d_ptd_r[PT_W-1:DATA_W]);
  assign td_den_nxt = DIV_W'(d_td_den_r);

  always_ff @(posedge clk) begin
    if (en) begin
      e_kp_rem_r <= kp_rem_nxt;
      e_kp_den_r <= kp_den_nxt;
      e_kp_low_r <= kp_dvd[DATA_W-1:0];
      e_kp_sat_r <= kp_rem_nxt >= kp_den_nxt;
      e_ti_rem_r <= ti_rem_nxt;
      e_ti_den_r <= ti_den_nxt;
      e_ti_low_r <= d_pti_r[DATA_W-1:0];
      e_ti_sat_r <= ti_rem_nxt >= ti_den_nxt;
      e_td_rem_r <= td_rem_nxt;
      e_td_den_r <= td_den_nxt;
      e_td_low_r <= d_ptd_r[DATA_W-1:0];
      e_td_sat_r <= td_rem_nxt >= td_den_nxt;
      e_mid_r    <= d_mid_r;
    end
  end

  pidcc_div u_div_kp (
    .clk    (clk),
    .en     (en),
    .rem_in (e_kp_rem_r),
    .low_in (e_kp_low_r),
    .den_in (e_kp_den_r),
    .sat_in (e_kp_sat_r),
    .quo    (kp_quo),
    .sat    (kp_sat)
  );

  pidcc_div u_div_ti (
    .clk    (clk),
    .en     (en),
    .rem_in (e_ti_rem_r),
    .low_in (e_ti_low_r),
    .den_in (e_ti_den_r),
    .sat_in (e_ti_sat_r),
    .quo    (ti_quo),
    .sat    (ti_sat)
  );

  pidcc_div u_div_td (
    .clk    (clk),
    .en     (en),
    .rem_in (e_td_rem_r),
    .low_in (e_td_low_r),
    .den_in (e_td_den_r),
    .sat_in (e_td_sat_r),
    .quo    (td_quo),
    .sat    (td_sat)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      mid_r[0] <= e_mid_r;
      for (int k = 1; k < DIV_STEPS; k++) begin
        mid_r[k] <= mid_r[k-1];
      end
    end
  end

  assign mid_end = mid_r[DIV_STEPS-1];

  // Stage F: saturate, then apply mode and invalid-model masking.
  always_ff @(posedge clk) begin
    if (en) begin
      f_inv_r <= mid_end.inv;
      if (mid_end.inv) begin
        f_kp_r <= '0;
      end else begin
        f_kp_r <= kp_sat ? '1 : kp_quo;
      end
      if (mid_end.inv || !(mid_end.mode == MODE_PI || mid_end.mode == MODE_PID)) begin
        f_ti_r <= '0;
      end else begin
        f_ti_r <= ti_sat ? '1 : ti_quo;
      end
      if (mid_end.inv || !mid_end.td_pos ||
          !(mid_end.mode == MODE_PD || mid_end.mode == MODE_PID)) begin
        f_td_r <= '0;
      end else begin
        f_td_r <= td_sat ? '1 : td_quo;
      end
    end
  end

  // Stage G: inputs of the Ki divider and the square root, and Kp*Td.
  assign ki_dvd = {f_kp_r, {FRAC_BITS{1'b0}}};
  assign ki_hi  = DATA_W'(ki_dvd[KID_W-1:DATA_W]);

  always_ff @(posedge clk) begin
    if (en) begin
      g_ki_rem_r       <= DIV_W'(ki_hi);
      g_ki_den_r       <= DIV_W'(f_ti_r);
      g_ki_low_r       <= ki_dvd[DATA_W-1:0];
      g_ki_sat_r       <= ki_hi >= f_ti_r;
      g_rad_r          <= (2*DATA_W)'(f_ti_r) * (2*DATA_W)'(f_td_r);
      g_late_r.inv     <= f_inv_r;
      g_late_r.kp      <= f_kp_r;
      g_late_r.ti      <= f_ti_r;
      g_late_r.td      <= f_td_r;
      g_late_r.kd_prod <= (2*DATA_W)'(f_kp_r) * (2*DATA_W)'(f_td_r);
    end
  end

  pidcc_div u_div_ki (
    .clk    (clk),
    .en     (en),
    .rem_in (g_ki_rem_r),
    .low_in (g_ki_low_r),
    .den_in (g_ki_den_r),
    .sat_in (g_ki_sat_r),
    .quo    (ki_quo),
    .sat    (ki_sat)
  );

  pidcc_sqrt u_sqrt (
    .clk    (clk),
    .en     (en),
    .rad_in (g_rad_r),
    .root   (tt_root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      late_r[0] <= g_late_r;
      for (int k = 1; k < DIV_STEPS; k++) begin
        late_r[k] <= late_r[k-1];
      end
    end
  end

  assign late_end = late_r[DIV_STEPS-1];

  // Output register.
  always_ff @(posedge clk) begin
    if (en) begin
      out_status_r <= late_end.inv;
      out_kp_r     <= late_end.kp;
      out_ti_r     <= late_end.ti;
      out_td_r     <= late_end.td;
      if (late_end.ti == '0) begin
        out_ki_r <= '0;
      end else begin
        out_ki_r <= ki_sat ? '1 : ki_quo;
      end
      if (late_end.kd_prod[2*DATA_W-1:DATA_W+FRAC_BITS] != '0) begin
        out_kd_r <= '1;
      end else begin
        out_kd_r <= late_end.kd_prod[DATA_W+FRAC_BITS-1:FRAC_BITS];
      end
      if (late_end.ti != '0 && late_end.td != '0) begin
        out_tt_r <= tt_root;
      end else begin
        out_tt_r <= late_end.ti;
      end
    end
  end

  assign out_valid           = vld_r[PIPE_LEN-1];
  assign out_status          = out_status_r;
  assign out_prop_gain       = out_kp_r;
  assign out_integral_time   = out_ti_r;
  assign out_derivative_time = out_td_r;
  assign out_integral_gain   = out_ki_r;
  assign out_derivative_gain = out_kd_r;
  assign out_tracking_time   = out_tt_r;

  assign chk_inv     = out_valid && out_status;
  assign chk_zero    = (out_prop_gain == '0) && (out_integral_time == '0) &&
                       (out_derivative_time == '0);
  assign chk_no_ti   = out_valid && (out_integral_time == '0);
  assign chk_no_td   = out_valid && (out_derivative_time == '0);
  assign chk_ki_zero = (out_integral_gain == '0);
  assign chk_tt_ti   = (out_tracking_time == out_integral_time);

  `ASSERT_RESET(a_reset_clears, clk, rst_n, !out_valid, "output valid after reset")
  `ASSERT_CLK(a_stall_holds, clk, rst_n, !en |=> $stable(vld_r), "pipeline moved in a stall")
  `ASSERT_CLK(a_invalid_zero, clk, rst_n, chk_inv |-> chk_zero, "invalid model with settings")
  `ASSERT_CLK(a_ki_zero, clk, rst_n, chk_no_ti |-> chk_ki_zero, "integral gain without Ti")
  `ASSERT_CLK(a_tt_default, clk, rst_n, chk_no_td |-> chk_tt_ti, "tracking time is not Ti")

endmodule

>>> tb/tb_pid_tuning_from_step_model_unit.sv
module tb_pid_tuning_from_step_model_unit;
  import pidcc_pkg::*;

  localparam int LATENCY = 72;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic        status;
    logic [31:0] kp;
    logic [31:0] ti;
    logic [31:0] td;
    logic [31:0] ki;
    logic [31:0] kd;
    logic [31:0] tt;
  } tuning_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_process_gain;
  logic [31:0] in_time_constant;
  logic [31:0] in_dead_time;
  logic [3:0]  in_lag_order;
  logic [1:0]  in_controller_mode;
  logic        out_valid;
  logic        out_ready;
  logic        out_status;
  logic [31:0] out_prop_gain;
  logic [31:0] out_integral_time;
  logic [31:0] out_derivative_time;
  logic [31:0] out_integral_gain;
  logic [31:0] out_derivative_gain;
  logic [31:0] out_tracking_time;

  tuning_t expected_tunings[$];
  int      mismatch_count;
  int      result_count;
  int      request_count;
  int      idle_cycles;
  bit      quiet_phase;
  bit      hold_off;
  bit      hold_started;
  int      hold_off_cycles;
  int      rx_idle;

  pid_tuning_from_step_model_unit u_top (.*);

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Truncating division saturated at 32 bits; a zero divisor saturates.
  function automatic logic [31:0] div_sat(logic [127:0] num, logic [127:0] den);
    logic [127:0] q;
    if (den == 0) return 32'hFFFFFFFF;
    q = num / den;
    if (q > 128'hFFFFFFFF) return 32'hFFFFFFFF;
    return q[31:0];
  endfunction

  function automatic logic [31:0] isqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      b = r | (64'd1 << i);
      if (b * b <= x) r = b;
    end
    return r[31:0];
  endfunction

  function automatic tuning_t tune_model(logic [31:0] k, logic [31:0] t, logic [31:0] l,
                                         logic [3:0] n, mode_t m);
    tuning_t res;
    logic [127:0] t2;
    logic [127:0] l2;
    logic [127:0] a;
    logic [127:0] b;
    logic [127:0] prod;
    res = '0;
    if (k == 0 || t == 0 || n == 0) begin
      res.status = 1'b1;
      return res;
    end
    t2 = t * (n + 128'd1);
    l2 = 2 * l + (n - 128'd1) * t;
    if (l2 == 0) begin
      res.status = 1'b1;
      return res;
    end
    case (m)
      MODE_P:  begin a = 1000; b = 333; end
      MODE_PI: begin a = 900;  b = 83;  end
      MODE_PD: begin a = 1240; b = 120; end
      default: begin a = 1350; b = 270; end
    endcase
    res.kp = div_sat((a * t2 + b * l2) << (2 * FRAC_BITS), 1000 * k * l2);
    case (m)
      MODE_PI:
        res.ti = div_sat(l2 * (3330 * t2 + 300 * l2), 2 * (1000 * t2 + 2200 * l2));
      MODE_PD:
        if (270 * t2 > 36 * l2)
          res.td = div_sat(l2 * (270 * t2 - 36 * l2), 2 * (1000 * t2 + 870 * l2));
      MODE_PID: begin
        res.ti = div_sat(l2 * (2500 * t2 + 460 * l2), 2 * (1000 * t2 + 610 * l2));
        res.td = div_sat(l2 * (370 * t2), 2 * (1000 * t2 + 190 * l2));
      end
      default: ;
    endcase
    if (res.ti != 0) res.ki = div_sat({96'd0, res.kp} << FRAC_BITS, {96'd0, res.ti});
    prod = ({96'd0, res.kp} * {96'd0, res.td}) >> FRAC_BITS;
    res.kd = (prod > 128'hFFFFFFFF) ? 32'hFFFFFFFF : prod[31:0];
    res.tt = (res.ti != 0 && res.td != 0) ? isqrt({32'd0, res.ti} * {32'd0, res.td}) : res.ti;
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on result %0d: %s got %h expected %h", result_count, field, got, want);
    mismatch_count++;
  endtask

  task automatic send_model(logic [31:0] k, logic [31:0] t, logic [31:0] l,
                            logic [3:0] n, logic [1:0] m);
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_process_gain <= k;
    in_time_constant <= t;
    in_dead_time <= l;
    in_lag_order <= n;
    in_controller_mode <= m;
    expected_tunings.push_back(tune_model(k, t, l, n, mode_t'(m)));
    do @(posedge clk); while (!in_ready);
    request_count++;
  endtask

  task automatic pause_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(1, 32'h000FFFFF);
      2: return $urandom_range(32'h00004000, 32'h00100000);
      3: return $urandom_range(32'h00010000, 32'h00400000);
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  task automatic send_random_model();
    send_model(rand_q(), rand_q(), rand_q(), 4'($urandom_range(0, 15)),
               2'($urandom_range(0, 3)));
  endtask

  task automatic test_directed();
    for (int m = 0; m < 4; m++) begin
      send_model(32'h00010000, 32'h00050000, 32'h00010000, 4'd1, 2'(m));
      send_model(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 4'd15, 2'(m));
      send_model(32'd1, 32'hFFFFFFFF, 32'd1, 4'd1, 2'(m));
    end
    send_model(32'd0, 32'h00010000, 32'h00010000, 4'd1, MODE_PID);
    send_model(32'h00010000, 32'd0, 32'h00010000, 4'd1, MODE_PID);
    send_model(32'h00010000, 32'h00010000, 32'h00010000, 4'd0, MODE_PID);
    send_model(32'h00010000, 32'h00010000, 32'd0, 4'd1, MODE_PI);
    send_model(32'h00010000, 32'h00010000, 32'd0, 4'd3, MODE_PID);
    send_model(32'h00010000, 32'h00010000, 32'h00200000, 4'd1, MODE_PD);
    send_model(32'h00010000, 32'h00010000, 32'h00070000, 4'd1, MODE_PD);
    send_model(32'h00000100, 32'h00640000, 32'h00000001, 4'd1, MODE_PID);
    send_model(32'h00008000, 32'h00030000, 32'h00020000, 4'd8, MODE_PI);
  endtask

  task automatic test_random(int count);
    repeat (count) send_random_model();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    repeat (200) send_random_model();
  endtask

  task automatic test_drain_pause();
    repeat (20) send_random_model();
    pause_input();
    wait (expected_tunings.size() == 0);
    repeat (20) send_random_model();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_off_cycles <= 0;
      hold_started <= 1'b0;
      rx_idle <= 0;
    end else if (hold_off_cycles > 0) begin
      out_ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else if (hold_off && !hold_started) begin
      out_ready <= 1'b0;
      hold_off_cycles <= 150;
      hold_started <= 1'b1;
    end else if (rx_idle > 0) begin
      out_ready <= 1'b0;
      rx_idle <= rx_idle - 1;
    end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      rx_idle <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    tuning_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_tunings.size() == 0) begin
        $display("unexpected result %0d", result_count);
        mismatch_count++;
      end else begin
        want = expected_tunings.pop_front();
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_prop_gain !== want.kp) report_mismatch("prop_gain", out_prop_gain, want.kp);
        if (out_integral_time !== want.ti)
          report_mismatch("integral_time", out_integral_time, want.ti);
        if (out_derivative_time !== want.td)
          report_mismatch("derivative_time", out_derivative_time, want.td);
        if (out_integral_gain !== want.ki)
          report_mismatch("integral_gain", out_integral_gain, want.ki);
        if (out_derivative_gain !== want.kd)
          report_mismatch("derivative_gain", out_derivative_gain, want.kd);
        if (out_tracking_time !== want.tt)
          report_mismatch("tracking_time", out_tracking_time, want.tt);
      end
      result_count++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_pid_tuning_from_step_model_unit: FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_process_gain = '0;
    in_time_constant = '0;
    in_dead_time = '0;
    in_lag_order = '0;
    in_controller_mode = '0;
    mismatch_count = 0;
    result_count = 0;
    request_count = 0;
    quiet_phase = 1'b0;
    hold_off = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(600);
    test_backpressure();
    test_drain_pause();
    test_random(400);
    quiet_phase = 1'b1;
    test_random(150);
    pause_input();
    wait (expected_tunings.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Covered %0d requests and %0d results over all modes, invalid models,",
             request_count, result_count);
    $display("saturation, output stalls and a full pipeline.");
    if (mismatch_count == 0 && expected_tunings.size() == 0) begin
      $display("tb_pid_tuning_from_step_model_unit: PASS");
    end else begin
      $display("tb_pid_tuning_from_step_model_unit: FAIL");
    end
    $finish;
  end

endmodule
